// File: rtl/ccm_pkg.sv
package ccm_pkg;

  localparam int COORD_W   = 24;
  localparam int RADIUS_W  = 23;
  localparam int RSUM_W    = 24;
  localparam int SQ_W      = 48;
  localparam int DSQ_W     = 49;
  localparam int ROOT_W    = 52;
  localparam int DIST_W    = 25;
  localparam int REM_W     = 40;
  localparam int Q_W       = 15;
  localparam int NORM_W    = 16;
  localparam int FRAC_N    = 14;

  localparam int SQRT_STEPS = 26;
  localparam int DIV_STEPS  = 15;
  // back pipe: load, root steps, divide setup, divide steps
  localparam int DIV_SETUP  = SQRT_STEPS + 1;
  localparam int LAST_STAGE = DIV_SETUP + DIV_STEPS;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [NORM_W-1:0] NORMAL_ONE = NORM_W'(16384);

  localparam int IN_W  = 144;
  localparam int OUT_W = 64;

  // item handed from front to back through the queue
  typedef struct packed {
    logic                hit;
    logic                sx;
    logic                sy;
    logic [COORD_W-1:0]  ax;
    logic [COORD_W-1:0]  ay;
    logic [RADIUS_W-1:0] r1;
    logic [RSUM_W-1:0]   rsum;
    logic [DSQ_W-1:0]    dist_sq;
  } pair_t;

  // one stage of the back pipe
  typedef struct packed {
    logic                hit;
    logic                sx;
    logic                sy;
    logic [COORD_W-1:0]  ax;
    logic [COORD_W-1:0]  ay;
    logic [RADIUS_W-1:0] r1;
    logic [RSUM_W-1:0]   rsum;
    logic [ROOT_W-1:0]   rx;
    logic [ROOT_W-1:0]   res;
    logic [REM_W-1:0]    remx;
    logic [REM_W-1:0]    remy;
    logic [Q_W-1:0]      qx;
    logic [Q_W-1:0]      qy;
  } stage_t;

endpackage

// File: rtl/ccm_front.sv
module ccm_front
  import ccm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COORD_W-1:0]  first_x,
  input  logic [COORD_W-1:0]  first_y,
  input  logic [RADIUS_W-1:0] first_radius,
  input  logic [COORD_W-1:0]  second_x,
  input  logic [COORD_W-1:0]  second_y,
  input  logic [RADIUS_W-1:0] second_radius,
  input  logic                q_full,
  output logic                q_push,
  output pair_t               q_data
);

  logic                va, vb;
  logic                en;
  logic                a_sx, a_sy, b_sx, b_sy;
  logic [COORD_W-1:0]  a_ax, a_ay, b_ax, b_ay;
  logic [RADIUS_W-1:0] a_r1, b_r1;
  logic [RSUM_W-1:0]   a_rsum, b_rsum;
  logic [SQ_W-1:0]     sqx, sqy, rs2;
  logic [COORD_W:0]    dx, dy;
  logic [DSQ_W-1:0]    dist_sq;

  assign en       = !vb || !q_full;
  assign in_ready = en;

  // coordinate differences
  assign dx = {first_x[COORD_W-1], first_x} - {second_x[COORD_W-1], second_x};
  assign dy = {first_y[COORD_W-1], first_y} - {second_y[COORD_W-1], second_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
    end
  end

  // stage A: magnitudes and radius sum
  always_ff @(posedge clk) begin
    if (en) begin
      a_sx   <= dx[COORD_W];
      a_sy   <= dy[COORD_W];
      a_ax   <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      a_ay   <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      a_r1   <= first_radius;
      a_rsum <= RSUM_W'(first_radius) + RSUM_W'(second_radius);
    end
  end

  // stage B: squares
  always_ff @(posedge clk) begin
    if (en) begin
      b_sx   <= a_sx;
      b_sy   <= a_sy;
      b_ax   <= a_ax;
      b_ay   <= a_ay;
      b_r1   <= a_r1;
      b_rsum <= a_rsum;
      sqx    <= a_ax * a_ax;
      sqy    <= a_ay * a_ay;
      rs2    <= a_rsum * a_rsum;
    end
  end

  // overlap test on the way into the queue
  assign dist_sq = DSQ_W'(sqx) + DSQ_W'(sqy);
  assign q_push  = vb && !q_full;

  always_comb begin
    q_data.hit     = dist_sq <= DSQ_W'(rs2);
    q_data.sx      = b_sx;
    q_data.sy      = b_sy;
    q_data.ax      = b_ax;
    q_data.ay      = b_ay;
    q_data.r1      = b_r1;
    q_data.rsum    = b_rsum;
    q_data.dist_sq = dist_sq;
  end

endmodule

// File: rtl/ccm_queue.sv
module ccm_queue
  import ccm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  pair_t push_data,
  output logic  full,
  input  logic  pop,
  output pair_t pop_data,
  output logic  empty
);

  pair_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W+1)'(QDEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

// File: rtl/ccm_back.sv
module ccm_back
  import ccm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  output logic              q_pop,
  input  pair_t             q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              collided,
  output logic [RSUM_W-1:0] penetration,
  output logic [NORM_W-1:0] normal_x,
  output logic [NORM_W-1:0] normal_y
);

  stage_t            pipe [LAST_STAGE+1];
  logic              vld  [LAST_STAGE+1];
  logic              en;
  stage_t            fin;
  logic [DIST_W-1:0] droot;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  // load from the queue
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].hit  <= q_data.hit;
      pipe[0].sx   <= q_data.sx;
      pipe[0].sy   <= q_data.sy;
      pipe[0].ax   <= q_data.ax;
      pipe[0].ay   <= q_data.ay;
      pipe[0].r1   <= q_data.r1;
      pipe[0].rsum <= q_data.rsum;
      pipe[0].rx   <= ROOT_W'(q_data.dist_sq);
      pipe[0].res  <= '0;
      pipe[0].remx <= '0;
      pipe[0].remy <= '0;
      pipe[0].qx   <= '0;
      pipe[0].qy   <= '0;
    end
  end

  // root steps, divide setup, divide steps
  for (genvar s = 1; s <= LAST_STAGE; s++) begin : g_stage
    stage_t nxt;

    if (s <= SQRT_STEPS) begin : g_root
      localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (SQRT_STEPS - s));
      logic [ROOT_W-1:0] trial;
      assign trial = pipe[s-1].res + BIT;
      always_comb begin
        nxt = pipe[s-1];
        if (pipe[s-1].rx >= trial) begin
          nxt.rx  = pipe[s-1].rx - trial;
          nxt.res = (pipe[s-1].res >> 1) + BIT;
        end else begin
          nxt.res = pipe[s-1].res >> 1;
        end
      end
    end else if (s == DIV_SETUP) begin : g_setup
      logic [DIST_W-1:0] d;
      assign d = pipe[s-1].res[DIST_W-1:0];
      always_comb begin
        nxt = pipe[s-1];
        nxt.remx = (REM_W'(pipe[s-1].ax) << FRAC_N) + REM_W'(d >> 1);
        nxt.remy = (REM_W'(pipe[s-1].ay) << FRAC_N) + REM_W'(d >> 1);
        nxt.qx   = '0;
        nxt.qy   = '0;
      end
    end else begin : g_div
      localparam int QB = LAST_STAGE - s;
      logic [REM_W-1:0] dsh;
      assign dsh = REM_W'(pipe[s-1].res[DIST_W-1:0]) << QB;
      always_comb begin
        nxt = pipe[s-1];
        if (pipe[s-1].remx >= dsh) begin
          nxt.remx   = pipe[s-1].remx - dsh;
          nxt.qx[QB] = 1'b1;
        end
        if (pipe[s-1].remy >= dsh) begin
          nxt.remy   = pipe[s-1].remy - dsh;
          nxt.qy[QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else if (en) vld[s] <= vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) pipe[s] <= nxt;
    end
  end

  // result formatting into the output register
  assign fin   = pipe[LAST_STAGE];
  assign droot = fin.res[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[LAST_STAGE];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!fin.hit) begin
        collided    <= 1'b0;
        penetration <= '0;
        normal_x    <= '0;
        normal_y    <= '0;
      end else if (droot == '0) begin
        collided    <= 1'b1;
        penetration <= RSUM_W'(fin.r1);
        normal_x    <= NORMAL_ONE;
        normal_y    <= '0;
      end else begin
        collided    <= 1'b1;
        penetration <= fin.rsum - droot[RSUM_W-1:0];
        normal_x    <= fin.sx ? NORM_W'(-NORM_W'(fin.qx)) : NORM_W'(fin.qx);
        normal_y    <= fin.sy ? NORM_W'(-NORM_W'(fin.qy)) : NORM_W'(fin.qy);
      end
    end
  end

endmodule

// File: rtl/circle_collision_manifold_top.sv
// Circle-pair overlap test. One pair is taken every cycle unless the
// front stalls on a full queue. A result passes two front stages, the
// queue, 43 back stages and the output register; the depth is set by the
// pipelined square root, one result bit per stage over 26 stages, and by two
// restoring dividers, one quotient bit per stage over 15 stages. A small
// queue between the distance test and the root/divide pipe lets each
// side stall alone. The result gives the collided flag, the penetration
// depth in Q16.8 and the normal from the second centre toward the first
// in Q1.14; coincident centres report the first radius and normal (1,0).
module circle_collision_manifold_top
  import ccm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // first_x, first_y, first_radius, second_x, second_y, second_radius
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // collided, penetration, normal_x, normal_y
  output logic [OUT_W-1:0] m_tdata
);

  pair_t             q_in, q_out;
  logic              q_push, q_pop, q_full, q_empty;
  logic              collided;
  logic [RSUM_W-1:0] penetration;
  logic [NORM_W-1:0] normal_x, normal_y;

  ccm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .first_x      (s_tdata[23:0]),
    .first_y      (s_tdata[47:24]),
    .first_radius (s_tdata[70:48]),
    .second_x     (s_tdata[94:71]),
    .second_y     (s_tdata[118:95]),
    .second_radius(s_tdata[141:119]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  ccm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  ccm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_out),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .collided   (collided),
    .penetration(penetration),
    .normal_x   (normal_x),
    .normal_y   (normal_y)
  );

  assign m_tdata = {7'b0, normal_y, normal_x, penetration, collided};

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[56:1] == '0)
    else $error("miss with nonzero payload");

  // normal x stays within unit magnitude
  a_norm_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[40:25]) <= 16384 && $signed(m_tdata[40:25]) >= -16384))
    else $error("normal x out of range");

  // input stalls only on a full queue behind a loaded front
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_full && !q_push)
    else $error("front stalled without full queue");

endmodule
